### hw/rtl/otbs_pkg.sv
// Shared types and constants of the oscillator trim binary search block.
// Phase codes, result kinds, register indexes and fixed field widths.
// Depends on nothing.
package otbs_pkg;

    // Fixed widths of the interface
    localparam int TRIM_BITS   = 7;
    localparam int TOL_BITS    = 10;
    localparam int KIND_BITS   = 2;
    localparam int PHASE_BITS  = 3;
    localparam int INDEX_BITS  = 1;
    localparam int FACTOR_BITS = 11;

    // Reset values of the configuration registers
    localparam int MAX_CODE_RESET = 127;
    localparam int TOL_RESET      = 150;

    // Scale of the tolerance
    localparam int PERMILLE = 1000;

    // Register indexes
    localparam logic [INDEX_BITS-1:0] REG_MAX_CODE = 1'd0;
    localparam logic [INDEX_BITS-1:0] REG_TOL      = 1'd1;

    // Request opcodes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_MEASURE = 1'b1;

    // Result kinds
    typedef logic [KIND_BITS-1:0] kind_t;
    localparam kind_t KIND_MEASURE = 2'd0;
    localparam kind_t KIND_PASS    = 2'd1;
    localparam kind_t KIND_FAIL    = 2'd2;
    localparam kind_t KIND_IGNORED = 2'd3;

    // Sequencer phases
    typedef logic [PHASE_BITS-1:0] phase_t;
    localparam phase_t PH_IDLE   = 3'd0;
    localparam phase_t PH_SEARCH = 3'd1;
    localparam phase_t PH_LOW    = 3'd2;
    localparam phase_t PH_HIGH   = 3'd3;
    localparam phase_t PH_FINAL  = 3'd4;

endpackage

### hw/rtl/otbs_bounds.sv
// Tolerance window products of the trim search: goal * (1000 - tol) and
// goal * (1000 + tol), registered once per cycle from stable state.
// Depends on otbs_pkg.
module otbs_bounds #(
    parameter int FREQ_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [FREQ_BITS-1:0]                   goal,
    input  logic [otbs_pkg::TOL_BITS-1:0]          tol,
    output logic [FREQ_BITS+otbs_pkg::FACTOR_BITS-1:0] lo_prod,
    output logic [FREQ_BITS+otbs_pkg::FACTOR_BITS-1:0] hi_prod
);

    localparam int PROD_BITS = FREQ_BITS + otbs_pkg::FACTOR_BITS;
    localparam int FB        = otbs_pkg::FACTOR_BITS;

    logic [FB-1:0]        tol_ext;
    logic [FB-1:0]        lo_factor;
    logic [FB-1:0]        hi_factor;
    logic [PROD_BITS-1:0] lo_prod_reg;
    logic [PROD_BITS-1:0] hi_prod_reg;
    logic [PROD_BITS-1:0] lo_prod_next;
    logic [PROD_BITS-1:0] hi_prod_next;

    assign tol_ext = FB'(tol);

    // Saturate the lower factor at zero for tolerances above 1000
    assign lo_factor = (tol_ext < FB'(otbs_pkg::PERMILLE)) ?
                       (FB'(otbs_pkg::PERMILLE) - tol_ext) : '0;
    assign hi_factor = FB'(otbs_pkg::PERMILLE) + tol_ext;

    assign lo_prod_next = PROD_BITS'(goal) * PROD_BITS'(lo_factor);
    assign hi_prod_next = PROD_BITS'(goal) * PROD_BITS'(hi_factor);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_prod_reg <= '0;
            hi_prod_reg <= '0;
        end
        else
        begin
            lo_prod_reg <= lo_prod_next;
            hi_prod_reg <= hi_prod_next;
        end
    end

    assign lo_prod = lo_prod_reg;
    assign hi_prod = hi_prod_reg;

endmodule

### hw/rtl/otbs_core.sv
// Search sequencer of the trim calibration: bounds, probe code, goal and
// error state, and the result of one request.
// Depends on otbs_pkg.
module otbs_core #(
    parameter int CODE_BITS = 7,
    parameter int FREQ_BITS = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       step,
    input  logic                                       op,
    input  logic [FREQ_BITS-1:0]                       target,
    input  logic [FREQ_BITS-1:0]                       meas,
    input  logic [CODE_BITS-1:0]                       max_code,
    input  logic [FREQ_BITS+otbs_pkg::FACTOR_BITS-1:0] lo_prod,
    input  logic [FREQ_BITS+otbs_pkg::FACTOR_BITS-1:0] hi_prod,
    output logic [FREQ_BITS-1:0]                       goal,
    output otbs_pkg::kind_t                            res_kind,
    output logic [CODE_BITS-1:0]                       res_code
);

    localparam int PROD_BITS = FREQ_BITS + otbs_pkg::FACTOR_BITS;

    otbs_pkg::phase_t       phase_reg, phase_next;
    logic [CODE_BITS-1:0]   low_code_reg, low_code_next;
    logic [CODE_BITS-1:0]   high_code_reg, high_code_next;
    logic [CODE_BITS-1:0]   probe_code_reg, probe_code_next;
    logic [FREQ_BITS-1:0]   goal_reg, goal_next;
    logic [FREQ_BITS-1:0]   low_error_reg, low_error_next;

    logic [CODE_BITS-1:0]   base_low;
    logic [CODE_BITS-1:0]   base_high;
    logic [CODE_BITS:0]     code_sum;
    logic [CODE_BITS-1:0]   mid;
    logic [FREQ_BITS-1:0]   meas_err;
    logic [PROD_BITS-1:0]   meas_x1000;
    logic [PROD_BITS-1:0]   meas_x1000_up;
    logic                   fail;

    // New bounds: full range on start, else narrow around the probe
    always_comb
    begin
        if (op == otbs_pkg::OP_START)
        begin
            base_low  = '0;
            base_high = max_code;
        end
        else if (meas > goal_reg)
        begin
            base_low  = low_code_reg;
            base_high = probe_code_reg;
        end
        else
        begin
            base_low  = probe_code_reg;
            base_high = high_code_reg;
        end
    end

    assign code_sum = (CODE_BITS+1)'(base_low) + (CODE_BITS+1)'(base_high);
    assign mid      = code_sum[CODE_BITS:1];

    assign meas_err = (meas >= goal_reg) ? (meas - goal_reg) : (goal_reg - meas);

    // meas < goal*lo/1000 (truncated) <=> 1000*(meas+1) <= goal*lo
    // meas > goal*hi/1000 (truncated) <=> 1000*meas > goal*hi
    assign meas_x1000    = PROD_BITS'(meas) * PROD_BITS'(otbs_pkg::PERMILLE);
    assign meas_x1000_up = meas_x1000 + PROD_BITS'(otbs_pkg::PERMILLE);
    assign fail          = (meas_x1000_up <= lo_prod) || (meas_x1000 > hi_prod);

    always_comb
    begin
        phase_next      = phase_reg;
        low_code_next   = low_code_reg;
        high_code_next  = high_code_reg;
        probe_code_next = probe_code_reg;
        goal_next       = goal_reg;
        low_error_next  = low_error_reg;
        res_kind        = otbs_pkg::KIND_MEASURE;
        res_code        = '0;

        if (op == otbs_pkg::OP_START || phase_reg == otbs_pkg::PH_SEARCH)
        begin
            if (op == otbs_pkg::OP_START)
            begin
                goal_next = target;
            end
            low_code_next  = base_low;
            high_code_next = base_high;
            if (mid == base_low)
            begin
                phase_next      = otbs_pkg::PH_LOW;
                probe_code_next = base_low;
            end
            else
            begin
                phase_next      = otbs_pkg::PH_SEARCH;
                probe_code_next = mid;
            end
            res_code = probe_code_next;
        end
        else
        begin
            unique case (phase_reg)
                otbs_pkg::PH_LOW:
                begin
                    low_error_next  = meas_err;
                    phase_next      = otbs_pkg::PH_HIGH;
                    probe_code_next = high_code_reg;
                    res_code        = high_code_reg;
                end
                otbs_pkg::PH_HIGH:
                begin
                    // Tie goes to the upper bound
                    probe_code_next = (low_error_reg < meas_err) ? low_code_reg
                                                                 : high_code_reg;
                    phase_next      = otbs_pkg::PH_FINAL;
                    res_code        = probe_code_next;
                end
                otbs_pkg::PH_FINAL:
                begin
                    res_kind   = fail ? otbs_pkg::KIND_FAIL : otbs_pkg::KIND_PASS;
                    res_code   = probe_code_reg;
                    phase_next = otbs_pkg::PH_IDLE;
                end
                default:
                begin
                    res_kind = otbs_pkg::KIND_IGNORED;
                    res_code = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= otbs_pkg::PH_IDLE;
            low_code_reg   <= '0;
            high_code_reg  <= '0;
            probe_code_reg <= '0;
            goal_reg       <= '0;
            low_error_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            low_code_reg   <= low_code_next;
            high_code_reg  <= high_code_next;
            probe_code_reg <= probe_code_next;
            goal_reg       <= goal_next;
            low_error_reg  <= low_error_next;
        end
    end

    assign goal = goal_reg;

endmodule

### hw/rtl/oscillator_trim_binary_search.sv
// Top level of the oscillator trim binary search: input register, result
// register, configuration registers and the search sequencer.
// Depends on otbs_pkg, otbs_bounds and otbs_core.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: op = start with
//   target_mhz, or op = measurement answer with measured_mhz. Every request
//   yields exactly one result on the output channel (out_valid / out_stall):
//   kind = measure request with the trim_code to measure next, pass or fail
//   with the final calibrated code, or ignored (code 0) for an answer that
//   arrives while no calibration runs. A start while busy restarts.
//   Configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   max_code (index 0) or tol_permille (index 1); cfg_ready is always high.
//   Write it only while no request is in flight.
// Timing:
//   A request passes through the input register, then through the sequencer
//   into the result register. One request per cycle is accepted while the
//   result side drains; the window check multiplies the goal by the tolerance
//   factors in a register stage of its own, always ready since at least three
//   answers follow each start.
// Reset and stall:
//   Reset empties both registers, sets the sequencer idle and loads
//   max_code 127 and tol_permille 150. While out_stall holds the result,
//   the input register still takes one more request, then in_stall rises.
module oscillator_trim_binary_search #(
    parameter int CODE_BITS = 7,
    parameter int FREQ_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  op,
    input  logic [FREQ_BITS-1:0]                  target_mhz,
    input  logic [FREQ_BITS-1:0]                  measured_mhz,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output otbs_pkg::kind_t                       kind,
    output logic [otbs_pkg::TRIM_BITS-1:0]        trim_code,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [otbs_pkg::INDEX_BITS-1:0]       cfg_index,
    input  logic [((CODE_BITS > otbs_pkg::TOL_BITS) ? CODE_BITS
                   : otbs_pkg::TOL_BITS)-1:0]     cfg_data
);

    localparam int PROD_BITS = FREQ_BITS + otbs_pkg::FACTOR_BITS;
    localparam int WIDE_BITS = (CODE_BITS > otbs_pkg::TRIM_BITS) ? CODE_BITS
                                                                 : otbs_pkg::TRIM_BITS;

    // Configuration registers
    logic [CODE_BITS-1:0]          max_code_reg;
    logic [otbs_pkg::TOL_BITS-1:0] tol_reg;

    // Input register
    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_op_reg;
    logic [FREQ_BITS-1:0]          s1_target_reg;
    logic [FREQ_BITS-1:0]          s1_meas_reg;

    // Result register
    logic                          out_valid_reg, out_valid_next;
    otbs_pkg::kind_t               kind_reg;
    logic [otbs_pkg::TRIM_BITS-1:0] trim_reg;

    logic                          in_accept;
    logic                          s1_advance;
    logic                          step;
    logic [FREQ_BITS-1:0]          goal;
    logic [PROD_BITS-1:0]          lo_prod;
    logic [PROD_BITS-1:0]          hi_prod;
    otbs_pkg::kind_t               res_kind;
    logic [CODE_BITS-1:0]          res_code;
    logic [WIDE_BITS-1:0]          res_code_wide;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_code_reg <= CODE_BITS'(otbs_pkg::MAX_CODE_RESET);
            tol_reg      <= otbs_pkg::TOL_BITS'(otbs_pkg::TOL_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                otbs_pkg::REG_MAX_CODE: max_code_reg <= cfg_data[CODE_BITS-1:0];
                otbs_pkg::REG_TOL:      tol_reg      <= cfg_data[otbs_pkg::TOL_BITS-1:0];
                default:                ;
            endcase
        end
    end

    // Advance the input register whenever the result register is free or drains
    assign s1_advance     = !out_valid_reg || !out_stall;
    assign step           = s1_valid_reg && s1_advance;
    assign in_stall       = s1_valid_reg && !s1_advance;
    assign in_accept      = in_valid && !in_stall;
    assign s1_valid_next  = in_accept || (s1_valid_reg && !s1_advance);
    assign out_valid_next = step || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the request payload until the sequencer takes it
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg     <= op;
            s1_target_reg <= target_mhz;
            s1_meas_reg   <= measured_mhz;
        end
    end

    otbs_bounds #(
        .FREQ_BITS (FREQ_BITS)
    ) u_bounds (
        .clk     (clk),
        .rst_n   (rst_n),
        .goal    (goal),
        .tol     (tol_reg),
        .lo_prod (lo_prod),
        .hi_prod (hi_prod)
    );

    otbs_core #(
        .CODE_BITS (CODE_BITS),
        .FREQ_BITS (FREQ_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .op       (s1_op_reg),
        .target   (s1_target_reg),
        .meas     (s1_meas_reg),
        .max_code (max_code_reg),
        .lo_prod  (lo_prod),
        .hi_prod  (hi_prod),
        .goal     (goal),
        .res_kind (res_kind),
        .res_code (res_code)
    );

    // The reported code keeps only the low TRIM_BITS bits of the sequencer code
    assign res_code_wide = WIDE_BITS'(res_code);

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            kind_reg <= res_kind;
            trim_reg <= res_code_wide[otbs_pkg::TRIM_BITS-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign trim_code = trim_reg;

endmodule

### hw/rtl/otbs_checker.sv
// Port-level checks of the oscillator trim binary search top level,
// attached by bind. Depends on otbs_pkg and oscillator_trim_binary_search.
module otbs_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  otbs_pkg::kind_t                kind,
    input  logic [otbs_pkg::TRIM_BITS-1:0] trim_code
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(trim_code))
        else $error("stalled result changed");

    // An empty result register never backs up the request side
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("request stalled while result register empty");

    // An accepted request reaches the result register once it may advance
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
        else $error("accepted request produced no result");

    // An ignored answer reports code zero
    a_ignored_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == otbs_pkg::KIND_IGNORED |-> trim_code == '0)
        else $error("ignored result with nonzero code");

endmodule

bind oscillator_trim_binary_search otbs_checker u_otbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .trim_code (trim_code)
);

### sim/tb_oscillator_trim_binary_search.sv
// Self-checking testbench for oscillator_trim_binary_search: feeds start and
// measurement requests, predicts each result and compares them field by field.
// Depends on otbs_pkg and the oscillator_trim_binary_search RTL.
module tb_oscillator_trim_binary_search;
    timeunit 1ns;
    timeprecision 1ps;

    import otbs_pkg::*;

    localparam int CODE_W           = 7;
    localparam int FREQ_W           = 16;
    localparam int CFG_W            = (CODE_W > TOL_BITS) ? CODE_W : TOL_BITS;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_CYCLES = 60;
    // two register stages from request to result, plus margin
    localparam int DRAIN_CYCLES     = 4;

    typedef struct packed {
        logic              op;
        logic [FREQ_W-1:0] target;
        logic [FREQ_W-1:0] meas;
    } trim_req_t;

    typedef struct packed {
        kind_t                kind;
        logic [TRIM_BITS-1:0] code;
    } trim_result_t;

    // DUT signals, all inputs known from time zero
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  op           = OP_START;
    logic [FREQ_W-1:0]     target_mhz   = '0;
    logic [FREQ_W-1:0]     measured_mhz = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    kind_t                 kind;
    logic [TRIM_BITS-1:0]  trim_code;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [INDEX_BITS-1:0] cfg_index    = REG_MAX_CODE;
    logic [CFG_W-1:0]      cfg_data     = '0;

    // Requests waiting to be offered, and results the block still owes us
    trim_req_t    req_backlog[$];
    trim_result_t trim_results_due[$];
    trim_req_t    head_req;
    trim_result_t due;

    // Shadow of the sequencer and its registers
    phase_t               cal_phase   = PH_IDLE;
    logic [TRIM_BITS-1:0] span_lo     = '0;
    logic [TRIM_BITS-1:0] span_hi     = '0;
    logic [TRIM_BITS-1:0] probe       = '0;
    logic [FREQ_W-1:0]    goal        = '0;
    logic [FREQ_W-1:0]    lo_err      = '0;
    logic [TRIM_BITS-1:0] max_code_sh = TRIM_BITS'(MAX_CODE_RESET);
    logic [TOL_BITS-1:0]  tol_sh      = TOL_BITS'(TOL_RESET);

    // Traffic shaping
    logic        quiet          = 1'b0;
    logic        long_hold      = 1'b0;
    logic        long_hold_done = 1'b0;
    int unsigned send_gap       = 0;
    int unsigned stall_left     = 0;
    int unsigned hold_left      = 0;

    // Bookkeeping
    int unsigned cycle_count = 0;
    int unsigned mismatches  = 0;
    int unsigned n_starts    = 0;
    int unsigned n_answers   = 0;
    int unsigned n_writes    = 0;
    int unsigned n_probes    = 0;
    int unsigned n_pass      = 0;
    int unsigned n_fail      = 0;
    int unsigned n_ignored   = 0;

    oscillator_trim_binary_search #(
        .CODE_BITS (CODE_W),
        .FREQ_BITS (FREQ_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .target_mhz   (target_mhz),
        .measured_mhz (measured_mhz),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .trim_code    (trim_code),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [FREQ_W-1:0] abs_gap(input logic [FREQ_W-1:0] a,
                                                  input logic [FREQ_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Pick the next code once the bounds moved; adjacent or equal bounds end the search
    function automatic void advance_probe();
        logic [TRIM_BITS:0] mid;
        mid = ({1'b0, span_lo} + {1'b0, span_hi}) >> 1;
        if (mid[TRIM_BITS-1:0] == span_lo)
        begin
            cal_phase = PH_LOW;
            probe     = span_lo;
        end
        else
        begin
            cal_phase = PH_SEARCH;
            probe     = mid[TRIM_BITS-1:0];
        end
    endfunction

    // Advance the shadow sequencer by one accepted request and queue the
    // result it must produce.
    task automatic predict_trim_result(input logic              req_op,
                                       input logic [FREQ_W-1:0] tgt,
                                       input logic [FREQ_W-1:0] meas);
        trim_result_t      res;
        logic [FREQ_W-1:0] err_now;
        longint unsigned   lo_factor;
        longint unsigned   lo_edge;
        longint unsigned   hi_edge;
        res.kind = KIND_MEASURE;
        res.code = '0;
        err_now  = abs_gap(meas, goal);
        if (req_op == OP_START)
        begin
            // a start always wins, even over a calibration in progress
            goal    = tgt;
            span_lo = '0;
            span_hi = max_code_sh;
            advance_probe();
            res.code = probe;
        end
        else
        begin
            case (cal_phase)
                PH_SEARCH:
                begin
                    if (meas > goal)
                        span_hi = probe;
                    else
                        span_lo = probe;
                    advance_probe();
                    res.code = probe;
                end
                PH_LOW:
                begin
                    lo_err    = err_now;
                    cal_phase = PH_HIGH;
                    probe     = span_hi;
                    res.code  = probe;
                end
                PH_HIGH:
                begin
                    // equal errors favor the upper bound
                    probe     = (lo_err < err_now) ? span_lo : span_hi;
                    cal_phase = PH_FINAL;
                    res.code  = probe;
                end
                PH_FINAL:
                begin
                    // lower factor clamps at zero for tolerances above 1000
                    lo_factor = (tol_sh < PERMILLE) ? longint'(PERMILLE) - tol_sh : 0;
                    lo_edge   = (longint'(goal) * lo_factor) / PERMILLE;
                    hi_edge   = (longint'(goal) * (longint'(PERMILLE) + tol_sh)) / PERMILLE;
                    res.kind  = (meas < lo_edge || meas > hi_edge) ? KIND_FAIL : KIND_PASS;
                    res.code  = probe;
                    cal_phase = PH_IDLE;
                end
                default:
                    res.kind = KIND_IGNORED;
            endcase
        end
        trim_results_due.push_back(res);
    endtask

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Request driver: score what the block takes, hold what it stalls,
    // otherwise idle in bursts or offer the next queued request.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_trim_result(op, target_mhz, measured_mhz);
                if (op == OP_START)
                    n_starts++;
                else
                    n_answers++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (req_backlog.size() == 0)
                    in_valid <= 1'b0;
                else if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    // start an idle burst; send_gap counts it down
                    send_gap <= $urandom_range(0, 6);
                    in_valid <= 1'b0;
                end
                else
                begin
                    head_req = req_backlog.pop_front();
                    op           <= head_req.op;
                    target_mhz   <= head_req.target;
                    measured_mhz <= head_req.meas;
                    in_valid     <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold: count down the stretch during which the
    // monitor keeps out_stall high so the input side backs up.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (long_hold && !long_hold_done)
        begin
            hold_left      <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Result monitor: check each taken result against the oldest
    // prediction, and drive out_stall (random bursts plus one long hold).
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (trim_results_due.size() == 0)
                    flag_mismatch("result with no request pending", 16'(kind), '0);
                else
                begin
                    due = trim_results_due.pop_front();
                    if (kind !== due.kind)
                        flag_mismatch("kind", 16'(kind), 16'(due.kind));
                    if (trim_code !== due.code)
                        flag_mismatch("trim_code", 16'(trim_code), 16'(due.code));
                end
                case (kind)
                    KIND_MEASURE: n_probes++;
                    KIND_PASS:    n_pass++;
                    KIND_FAIL:    n_fail++;
                    default:      n_ignored++;
                endcase
            end
            if (hold_left != 0)
                out_stall <= 1'b1;
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 6);
                out_stall  <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, trim_results_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Unused field of each request carries random junk so every bit toggles
    function automatic void push_start(input logic [FREQ_W-1:0] tgt);
        trim_req_t r;
        r.op     = OP_START;
        r.target = tgt;
        r.meas   = FREQ_W'($urandom);
        req_backlog.push_back(r);
    endfunction

    function automatic void push_answer(input logic [FREQ_W-1:0] meas);
        trim_req_t r;
        r.op     = OP_MEASURE;
        r.target = FREQ_W'($urandom);
        r.meas   = meas;
        req_backlog.push_back(r);
    endfunction

    // Wait until nothing is queued, offered or owed, then let the pipe settle
    task automatic wait_quiescent();
        do
            @(posedge clk);
        while (req_backlog.size() != 0 || in_valid || trim_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_BITS-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MAX_CODE)
            max_code_sh = TRIM_BITS'(value);
        else
            tol_sh = TOL_BITS'(value);
        n_writes++;
    endtask

    // Reprogram while idle, then queue mostly complete calibrations with
    // measurements near the target, some abandoned early, some with
    // trailing answers and some stray answers.
    task automatic run_phase(input int unsigned mc, input int unsigned tol,
                             input int unsigned n_items);
        int unsigned       made;
        int unsigned       steps;
        int unsigned       answers;
        int unsigned       pick;
        int                off;
        longint            f;
        logic [FREQ_W-1:0] tgt;
        wait_quiescent();
        write_reg(REG_MAX_CODE, mc);
        write_reg(REG_TOL, tol);
        // upper bound on search answers to narrow 0..mc to adjacent codes
        steps = 0;
        while ((1 << steps) < mc + 1)
            steps++;
        made = 0;
        while (made < n_items)
        begin
            pick = $urandom_range(0, 9);
            case ($urandom_range(0, 7))
                0:       tgt = '0;
                1:       tgt = '1;
                default: tgt = FREQ_W'($urandom_range(1, 65535));
            endcase
            if (pick == 0)
            begin
                repeat ($urandom_range(1, 3))
                    push_answer(FREQ_W'($urandom));
            end
            push_start(tgt);
            answers = steps + 3;
            if (pick == 1)
                answers = $urandom_range(0, answers - 1);
            else if (pick == 2)
                answers = answers + $urandom_range(1, 3);
            for (int i = 0; i < answers; i++)
            begin
                case ($urandom_range(0, 3))
                    0: f = $urandom_range(0, 65535);
                    1: f = longint'(tgt) + int'($urandom_range(0, 4)) - 2;
                    default:
                    begin
                        // land around the tolerance window edges
                        off = int'($urandom_range(0, 2 * tol + 60)) - int'(tol) - 30;
                        f = (longint'(tgt) * (1000 + off)) / 1000
                            + int'($urandom_range(0, 2)) - 1;
                    end
                endcase
                if (f < 0)
                    f = 0;
                else if (f > 65535)
                    f = 65535;
                push_answer(FREQ_W'(f));
            end
            made += 1 + answers;
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset settings: answer while idle, restart while busy,
        // then a full climb to the top of the range that passes.
        push_answer(16'hFFFF);
        push_start(16'h0000);
        push_answer(16'hFFFF);
        push_answer(16'hFFFF);
        push_start(16'hFFFF);
        repeat (7) push_answer(16'h0000);
        push_answer(16'hFFFF);
        push_answer(16'hFFFE);
        push_answer(16'hFFFF);

        // Directed, two-code range with zero tolerance: tie goes to the
        // upper code; exact hit passes, anything else fails.
        wait_quiescent();
        write_reg(REG_MAX_CODE, 1);
        write_reg(REG_TOL, 0);
        push_start(16'd100);
        push_answer(16'd99);
        push_answer(16'd101);
        push_answer(16'd100);
        push_start(16'd100);
        push_answer(16'd50);
        push_answer(16'd50);
        push_answer(16'd200);

        // Directed, empty range and tolerance above 1000 (lower edge at 0)
        wait_quiescent();
        write_reg(REG_MAX_CODE, 0);
        write_reg(REG_TOL, 1023);
        push_start(16'hFFFF);
        push_answer(16'h0000);
        push_answer(16'h0000);
        push_answer(16'h0000);

        // Random phases; the first one also backs up the input with a long
        // receiver hold while requests keep coming.
        run_phase(127, 150, 60);
        long_hold = 1'b1;
        run_phase(0, 0, 50);
        run_phase(127, 1023, 60);
        run_phase(1, 1000, 50);
        repeat (3)
            run_phase($urandom_range(0, 127), $urandom_range(0, 1023), 55);

        // Last stretch runs at full rate on both sides
        quiet = 1'b1;
        run_phase($urandom_range(0, 127), $urandom_range(0, 1023), 60);
        wait_quiescent();

        $display("Covered %0d calibration starts and %0d measurement answers over %0d register writes.",
                 n_starts, n_answers, n_writes);
        $display("Saw %0d measure requests, %0d pass, %0d fail, %0d ignored; %0d mismatches.",
                 n_probes, n_pass, n_fail, n_ignored, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
hw/rtl/otbs_pkg.sv
hw/rtl/otbs_bounds.sv
hw/rtl/otbs_core.sv
hw/rtl/oscillator_trim_binary_search.sv
hw/rtl/otbs_checker.sv
sim/tb_oscillator_trim_binary_search.sv
